// ----- rtl/greedy_graph_coloring_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the greedy graph colouring unit
// Shared property shapes for same-cycle and next-cycle checks.
// ---------------------------------------------------------------------------
`ifndef GREEDY_GRAPH_COLORING_UNIT_MACROS_SVH
`define GREEDY_GRAPH_COLORING_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GGC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GGC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ggc_pkg.sv -----
// ---------------------------------------------------------------------------
// ggc_pkg
// Types, constants and helpers shared by the greedy graph colouring unit.
// ---------------------------------------------------------------------------
package ggc_pkg;

  localparam int unsigned ROW_W             = 32;
  localparam int unsigned COLOR_SLOTS       = 32;
  localparam int unsigned COLOR_W           = 5;
  localparam int unsigned COUNT_W           = 6;
  localparam int unsigned MAX_NODES_DEFAULT = 32;
  localparam int unsigned TDATA_W           = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_PICK
  } state_t;

  typedef struct packed {
    logic               we;
    logic [COLOR_W-1:0] waddr;
    logic [COLOR_W-1:0] wdata;
    logic [COLOR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] node_color;
    logic [COUNT_W-1:0] colors_used;
    logic               last;
    logic               too_many_nodes;
  } result_t;

  // Lowest colour whose bit is clear; saturates to the top colour when all are taken.
  function automatic logic [COLOR_W-1:0] first_free(input logic [COLOR_SLOTS-1:0] taken);
    logic [COLOR_W-1:0] pick;
    pick = COLOR_W'(COLOR_SLOTS - 1);
    for (int i = COLOR_SLOTS - 1; i >= 0; i--) begin
      if (!taken[i]) begin
        pick = COLOR_W'(i);
      end
    end
    return pick;
  endfunction

endpackage

// ----- rtl/ggc_color_mem.sv -----
// ---------------------------------------------------------------------------
// ggc_color_mem
// Colour store: one write port and one registered read port.
// ---------------------------------------------------------------------------
module ggc_color_mem (
  input  logic                      clk,
  input  ggc_pkg::mem_req_t         req,
  output logic [ggc_pkg::COLOR_W-1:0] rdata
);
  import ggc_pkg::*;

  logic [COLOR_W-1:0] mem [COLOR_SLOTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

// ----- rtl/ggc_scan.sv -----
// ---------------------------------------------------------------------------
// ggc_scan
// Sequencer that reads one earlier node colour per cycle, marks it as taken when
// the row bit is set, then picks the lowest free colour and updates the graph state.
// ---------------------------------------------------------------------------
module ggc_scan #(
  parameter int unsigned MAX_NODES = ggc_pkg::MAX_NODES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ggc_pkg::ROW_W-1:0]     in_row,
  input  logic                          in_last,
  output logic                          res_valid,
  input  logic                          res_take,
  output ggc_pkg::result_t              res,
  output ggc_pkg::mem_req_t             mem_req,
  input  logic [ggc_pkg::COLOR_W-1:0]   mem_rdata
);
  import ggc_pkg::*;

  localparam int unsigned IDXW = $clog2(MAX_NODES + 1);
  localparam int unsigned EXTW = (IDXW > COUNT_W) ? IDXW : COUNT_W;

  state_t state, state_next;

  logic [IDXW-1:0]        node_index;
  logic [COUNT_W-1:0]     color_count;
  logic [ROW_W-1:0]       row;
  logic                   row_last;
  logic                   row_over;
  logic [COLOR_SLOTS-1:0] taken;
  logic [COLOR_W-1:0]     scan_addr;
  logic [COUNT_W-1:0]     scan_left;
  logic                   rd_valid;
  logic                   rd_bit;

  logic [EXTW-1:0]    idx_ext;
  logic               over;
  logic [COUNT_W-1:0] scan_len;
  logic [COLOR_W-1:0] pick;
  logic [COUNT_W-1:0] pick_count;
  logic [COUNT_W-1:0] count_next;
  logic               accept;
  logic               commit;

  assign idx_ext  = EXTW'(node_index);
  assign over     = idx_ext >= EXTW'(MAX_NODES);
  assign scan_len = (idx_ext >= EXTW'(COLOR_SLOTS)) ? COUNT_W'(COLOR_SLOTS)
                                                    : COUNT_W'(idx_ext);
  assign accept   = in_valid && in_ready;
  assign commit   = res_valid && res_take;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (over || scan_len == '0) begin
            state_next = ST_PICK;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_left == COUNT_W'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_PICK;
      end
      ST_PICK: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = (state == ST_IDLE);
    res_valid  = (state == ST_PICK);
    pick       = row_over ? '0 : first_free(taken);
    pick_count = COUNT_W'(pick) + COUNT_W'(1);
    count_next = (pick_count > color_count) ? pick_count : color_count;

    res.node_color     = pick;
    res.colors_used    = row_over ? color_count : count_next;
    res.last           = row_last;
    res.too_many_nodes = row_over;

    mem_req.raddr = scan_addr;
    mem_req.waddr = COLOR_W'(idx_ext);
    mem_req.wdata = pick;
    mem_req.we    = commit && !row_over && (idx_ext < EXTW'(COLOR_SLOTS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      node_index  <= '0;
      color_count <= '0;
      rd_valid    <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == ST_SCAN);
      if (commit) begin
        if (row_last) begin
          node_index  <= '0;
          color_count <= '0;
        end else if (!row_over) begin
          node_index  <= node_index + IDXW'(1);
          color_count <= count_next;
        end
      end
    end
  end

  // Read data arrives in the cycle after its address, so the row bit is registered alongside.
  always_ff @(posedge clk) begin
    rd_bit <= row[0];
    if (accept) begin
      row       <= in_row;
      row_last  <= in_last;
      row_over  <= over;
      taken     <= '0;
      scan_addr <= '0;
      scan_left <= scan_len;
    end else begin
      if (state == ST_SCAN) begin
        row       <= row >> 1;
        scan_addr <= scan_addr + COLOR_W'(1);
        scan_left <= scan_left - COUNT_W'(1);
      end
      if (rd_valid && rd_bit) begin
        taken[mem_rdata] <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/greedy_graph_coloring_unit.sv -----
// ---------------------------------------------------------------------------
// greedy_graph_coloring_unit
// First-fit greedy colouring of a graph, one adjacency row per beat.
// ---------------------------------------------------------------------------
// Usage:
//   Send the adjacency rows of a graph in node order on the slave channel,
//   bit v of tdata marking an edge to node v; tlast marks the final row.
//   Each row yields one result beat on the master channel: the node's colour,
//   the running colour count, tlast copied from the row, and tuser set when
//   the row lay beyond the node limit and was ignored.
//   Bits for nodes at or above the current row's index are ignored.
//   A row for node n > 0 reads the colour of each earlier node, up to 32 of
//   them, from the colour store, then passes a read drain state and a pick
//   state, where its result is loaded into the output register. Node 0 and
//   rows past the limit go straight to the pick state. One row is in flight
//   at a time; the next is accepted only once the previous result is loaded.
//   A result waits in the output register while the receiver stalls; the
//   next row may be accepted meanwhile but its result waits for the slot.
//   Reset clears the node index and colour count; the next row is node 0.
// ---------------------------------------------------------------------------
`include "greedy_graph_coloring_unit_macros.svh"

module greedy_graph_coloring_unit #(
  parameter int unsigned MAX_NODES = ggc_pkg::MAX_NODES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ggc_pkg::ROW_W-1:0]     s_tdata,   // [31:0] adjacency_row
  input  logic                          s_tlast,   // last_node
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ggc_pkg::TDATA_W-1:0]   m_tdata,   // [4:0] node_color, [10:5] colors_used
  output logic                          m_tlast,   // last
  output logic                          m_tuser    // too_many_nodes
);
  import ggc_pkg::*;

  logic                res_valid;
  logic                res_take;
  result_t             res;
  result_t             out_data;
  logic                out_valid;
  mem_req_t            mem_req;
  logic [COLOR_W-1:0]  mem_rdata;

  ggc_scan #(
    .MAX_NODES(MAX_NODES)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_row   (s_tdata),
    .in_last  (s_tlast),
    .res_valid(res_valid),
    .res_take (res_take),
    .res      (res),
    .mem_req  (mem_req),
    .mem_rdata(mem_rdata)
  );

  ggc_color_mem u_mem (
    .clk  (clk),
    .req  (mem_req),
    .rdata(mem_rdata)
  );

  assign res_take = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_data <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = TDATA_W'({out_data.colors_used, out_data.node_color});
  assign m_tlast  = out_data.last;
  assign m_tuser  = out_data.too_many_nodes;

  `GGC_ASSERT_NOW(a_color_below_count, clk, rst, m_tvalid && !m_tuser,
    m_tdata[4:0] < m_tdata[10:5], "colour not below colour count")
  `GGC_ASSERT_NOW(a_ignored_row_color, clk, rst, m_tvalid && m_tuser,
    m_tdata[4:0] == '0, "ignored row carries a non-zero colour")
  `GGC_ASSERT_NEXT(a_one_row_in_flight, clk, rst, s_tvalid && s_tready,
    !s_tready, "second row accepted while one is in flight")
  `GGC_ASSERT_NOW(a_write_on_commit, clk, rst, mem_req.we,
    res_valid && res_take && !res.too_many_nodes, "colour written without a result")

endmodule
